// ----- rtl/core/scpwm_pkg.sv -----
// ---------------------------------------------------------------------------
// scpwm_pkg
// Shared types and register map constants of the sixteen-channel pwm block.
// ---------------------------------------------------------------------------
package scpwm_pkg;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register map
   localparam logic [7:0] ADDR_MODE1    = 8'h00;
   localparam logic [7:0] ADDR_MODE2    = 8'h01;
   localparam logic [7:0] ADDR_CH_BASE  = 8'h06;
   localparam logic [7:0] ADDR_ALL_BASE = 8'hFA;
   localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

   // byte offsets within one channel
   localparam logic [1:0] BYTE_ON_L  = 2'd0;
   localparam logic [1:0] BYTE_ON_H  = 2'd1;
   localparam logic [1:0] BYTE_OFF_L = 2'd2;
   localparam logic [1:0] BYTE_OFF_H = 2'd3;

   localparam int unsigned BIT_SLEEP = 4;
   localparam int unsigned BIT_INVRT = 4;
   localparam int unsigned BIT_FULL  = 4;

   localparam logic [7:0] MODE1_MASK   = 8'h7F;
   localparam logic [7:0] MODE2_MASK   = 8'h1F;
   localparam logic [7:0] PRESCALE_MIN = 8'h03;

   localparam logic [7:0] MODE1_RESET    = 8'h11;
   localparam logic [7:0] MODE2_RESET    = 8'h04;
   localparam logic [7:0] PRESCALE_RESET = 8'h1E;
   localparam logic [7:0] FULL_OFF_RESET = 8'h10;

   localparam int unsigned PIN_BITS = 16;

   typedef struct packed {
      logic [7:0] off_h;
      logic [7:0] off_l;
      logic [7:0] on_h;
      logic [7:0] on_l;
   } chan_type;

endpackage

// ----- rtl/core/scpwm_pin_compare.sv -----
// ---------------------------------------------------------------------------
// scpwm_pin_compare
// Per-channel on/off window compare against the pwm counter, with full-on,
// full-off and output inversion.
// ---------------------------------------------------------------------------
module scpwm_pin_compare
   import scpwm_pkg::*;
#(
   parameter int CHANNELS     = 16,
   parameter int COUNTER_BITS = 12
) (
   input  chan_type [CHANNELS-1:0] chans,
   input  logic [COUNTER_BITS-1:0] count,
   input  logic                    invert,
   output logic [PIN_BITS-1:0]     pins
);

   localparam logic [15:0] CNT_MASK = 16'((32'd1 << COUNTER_BITS) - 32'd1);

   logic [15:0] cnt16;

   assign cnt16 = 16'(count);

   always_comb begin
      logic [15:0] on_v;
      logic [15:0] off_v;
      logic        level;
      pins = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         on_v  = {4'd0, chans[c].on_h[3:0], chans[c].on_l} & CNT_MASK;
         off_v = {4'd0, chans[c].off_h[3:0], chans[c].off_l} & CNT_MASK;
         if (chans[c].off_h[BIT_FULL]) begin
            level = 1'b0;
         end else if (chans[c].on_h[BIT_FULL]) begin
            level = 1'b1;
         end else if (on_v < off_v) begin
            level = (cnt16 >= on_v) && (cnt16 < off_v);
         end else if (on_v > off_v) begin
            level = (cnt16 >= on_v) || (cnt16 < off_v);
         end else begin
            level = 1'b0;
         end
         pins[c] = level ^ invert;
      end
   end

endmodule

// ----- rtl/core/sixteen_channel_pwm_register_block.sv -----
// ---------------------------------------------------------------------------
// sixteen_channel_pwm_register_block
// Register file and waveform core of a multi-channel 12-bit pwm led
// controller: byte writes, byte reads and oscillator ticks.
// ---------------------------------------------------------------------------
//  channel  | direction | tdata fields (lsb first)
//  req_     | in        | operation[1:0] reg_addr[9:2] write_data[17:10]
//  rsp_     | out       | read_data[7:0] pwm_pins[23:8]
//
//  one transaction a cycle while results are taken; input register then result
//  register, with the register update and pin compare between them.
//  synchronous reset loads the datasheet reset values at once, no sweep.
//  a stalled result holds the input register; a new request is still taken
//  whenever the input register moves on or is empty.
// ---------------------------------------------------------------------------
module sixteen_channel_pwm_register_block
   import scpwm_pkg::*;
#(
   parameter int CHANNELS     = 16,
   parameter int COUNTER_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // operation, reg_addr, write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // read_data, pwm_pins
);

   localparam logic [8:0] CH_TOP = 9'(ADDR_CH_BASE) + 9'(4 * CHANNELS);

   // input register
   logic       s1_valid_ff;
   logic [1:0] s1_op_ff;
   logic [7:0] s1_addr_ff;
   logic [7:0] s1_data_ff;

   // block state
   chan_type [CHANNELS-1:0] chan_ff, chan_in;
   logic [7:0]              mode1_ff, mode1_in;
   logic [7:0]              mode2_ff, mode2_in;
   logic [7:0]              pre_ff, pre_in;
   logic [7:0]              div_ff, div_in;
   logic [COUNTER_BITS-1:0] cnt_ff, cnt_in;

   // result register
   logic                rsp_valid_ff;
   logic [7:0]          rsp_rd_ff, rd_in;
   logic [PIN_BITS-1:0] rsp_pins_ff, pins_in;

   logic       advance;
   logic       fire;
   logic       accept;
   logic       ch_hit;
   logic       all_hit;
   logic [7:0] ch_off;
   logic [7:0] all_off;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign ch_off  = s1_addr_ff - ADDR_CH_BASE;
   assign all_off = s1_addr_ff - ADDR_ALL_BASE;
   assign ch_hit  = (s1_addr_ff >= ADDR_CH_BASE) && (9'(s1_addr_ff) < CH_TOP);
   assign all_hit = (s1_addr_ff >= ADDR_ALL_BASE) && (s1_addr_ff < ADDR_PRESCALE);

   function automatic logic [7:0] get_byte(chan_type ch, logic [1:0] k);
      logic [7:0] b;
      case (k)
         BYTE_ON_L:  b = ch.on_l;
         BYTE_ON_H:  b = ch.on_h;
         BYTE_OFF_L: b = ch.off_l;
         default:    b = ch.off_h;
      endcase
      return b;
   endfunction

   function automatic chan_type set_byte(chan_type ch, logic [1:0] k, logic [7:0] d);
      chan_type r;
      r = ch;
      case (k)
         BYTE_ON_L:  r.on_l  = d;
         BYTE_ON_H:  r.on_h  = d;
         BYTE_OFF_L: r.off_l = d;
         default:    r.off_h = d;
      endcase
      return r;
   endfunction

   // next state and read data for the transaction in the input register
   always_comb begin
      chan_in  = chan_ff;
      mode1_in = mode1_ff;
      mode2_in = mode2_ff;
      pre_in   = pre_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      rd_in    = '0;
      case (s1_op_ff)
         OP_WRITE: begin
            if (s1_addr_ff == ADDR_MODE1) begin
               mode1_in = s1_data_ff & MODE1_MASK;
            end else if (s1_addr_ff == ADDR_MODE2) begin
               mode2_in = s1_data_ff & MODE2_MASK;
            end else if (ch_hit) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (ch_off[5:2] == 4'(c)) begin
                     chan_in[c] = set_byte(chan_ff[c], ch_off[1:0], s1_data_ff);
                  end
               end
            end else if (all_hit) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  chan_in[c] = set_byte(chan_ff[c], all_off[1:0], s1_data_ff);
               end
            end else if (s1_addr_ff == ADDR_PRESCALE) begin
               if (mode1_ff[BIT_SLEEP]) begin
                  pre_in = (s1_data_ff < PRESCALE_MIN) ? PRESCALE_MIN : s1_data_ff;
               end
            end
         end
         OP_READ: begin
            if (s1_addr_ff == ADDR_MODE1) begin
               rd_in = mode1_ff;
            end else if (s1_addr_ff == ADDR_MODE2) begin
               rd_in = mode2_ff;
            end else if (ch_hit) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (ch_off[5:2] == 4'(c)) begin
                     rd_in = get_byte(chan_ff[c], ch_off[1:0]);
                  end
               end
            end else if (s1_addr_ff == ADDR_PRESCALE) begin
               rd_in = pre_ff;
            end
         end
         OP_TICK: begin
            if (!mode1_ff[BIT_SLEEP]) begin
               if (div_ff >= pre_ff) begin
                  div_in = '0;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  div_in = div_ff + 8'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   scpwm_pin_compare #(
      .CHANNELS     (CHANNELS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_compare (
      .chans  (chan_in),
      .count  (cnt_in),
      .invert (mode2_in[BIT_INVRT]),
      .pins   (pins_in)
   );

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode1_ff     <= MODE1_RESET;
         mode2_ff     <= MODE2_RESET;
         pre_ff       <= PRESCALE_RESET;
         div_ff       <= '0;
         cnt_ff       <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            chan_ff[c] <= '{off_h: FULL_OFF_RESET, off_l: 8'h00, on_h: 8'h00, on_l: 8'h00};
         end
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (fire) begin
            chan_ff  <= chan_in;
            mode1_ff <= mode1_in;
            mode2_ff <= mode2_in;
            pre_ff   <= pre_in;
            div_ff   <= div_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_tdata[1:0];
         s1_addr_ff <= req_tdata[9:2];
         s1_data_ff <= req_tdata[17:10];
      end
      if (fire) begin
         rsp_rd_ff   <= rd_in;
         rsp_pins_ff <= pins_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pins_ff, rsp_rd_ff};

   // prescale never drops below its minimum
   a_pre_min: assert property (@(posedge clock) disable iff (reset)
      pre_ff >= PRESCALE_MIN)
      else $error("prescale below minimum");

   // restart and reserved mode bits never stored
   a_mode_bits: assert property (@(posedge clock) disable iff (reset)
      !mode1_ff[7] && (mode2_ff[7:5] == 3'd0))
      else $error("reserved mode bits set");

   // counter and divider move only on an awake tick
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !(fire && (s1_op_ff == OP_TICK) && !mode1_ff[BIT_SLEEP]))
      |=> ($stable(cnt_ff) && $stable(div_ff)))
      else $error("counter moved without tick");

   // every processed transaction leaves a result
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      (!reset && fire) |=> rsp_valid_ff)
      else $error("result lost");

endmodule

// ----- tb/pwm_register_checker.sv -----
// ---------------------------------------------------------------------------
// pwm_register_checker
// Watches both streams of the pwm register block. It keeps its own register
// file, prescale divider and pwm counter, predicts the read byte and pin
// levels of every accepted request, and compares each result against them.
// ---------------------------------------------------------------------------
module pwm_register_checker
   import scpwm_pkg::*;
#(
   parameter int CHANNELS     = 16,
   parameter int COUNTER_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // operation, reg_addr, write_data
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // read_data, pwm_pins
   output int          error_count,
   output int          pending_results
);

   typedef struct packed {
      logic [7:0] write_data;
      logic [7:0] reg_addr;
      logic [1:0] operation;
   } reg_request_type;

   typedef struct packed {
      logic [15:0] pwm_pins;
      logic [7:0]  read_data;
   } pin_result_type;

   logic [7:0]              led_bytes [64];
   logic [7:0]              mode_one;
   logic [7:0]              mode_two;
   logic [7:0]              prescale;
   logic [7:0]              divider;
   logic [COUNTER_BITS-1:0] pwm_count;

   pin_result_type predicted_outputs [$];
   pin_result_type want;
   pin_result_type got;
   int             faults;

   function automatic void load_reset_values();
      for (int i = 0; i < 64; i++) begin
         led_bytes[i] = (i % 4 == int'(BYTE_OFF_H)) ? FULL_OFF_RESET : 8'h00;
      end
      mode_one  = MODE1_RESET;
      mode_two  = MODE2_RESET;
      prescale  = PRESCALE_RESET;
      divider   = '0;
      pwm_count = '0;
   endfunction

   function automatic logic [15:0] pin_levels();
      logic [15:0]             pins;
      logic [7:0]              on_h;
      logic [7:0]              off_h;
      logic [COUNTER_BITS-1:0] on_cnt;
      logic [COUNTER_BITS-1:0] off_cnt;
      logic                    level;
      pins = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         on_h    = led_bytes[4*c + int'(BYTE_ON_H)];
         off_h   = led_bytes[4*c + int'(BYTE_OFF_H)];
         on_cnt  = COUNTER_BITS'({on_h[3:0], led_bytes[4*c + int'(BYTE_ON_L)]});
         off_cnt = COUNTER_BITS'({off_h[3:0], led_bytes[4*c + int'(BYTE_OFF_L)]});
         // full off wins over full on
         if (off_h[BIT_FULL]) begin
            level = 1'b0;
         end else if (on_h[BIT_FULL]) begin
            level = 1'b1;
         end else if (on_cnt < off_cnt) begin
            level = (pwm_count >= on_cnt) && (pwm_count < off_cnt);
         end else if (on_cnt > off_cnt) begin
            level = (pwm_count >= on_cnt) || (pwm_count < off_cnt);
         end else begin
            level = 1'b0;
         end
         pins[c] = level ^ mode_two[BIT_INVRT];
      end
      return pins;
   endfunction

   function automatic void store_byte(logic [7:0] addr, logic [7:0] data);
      int offset;
      int k;
      offset = int'(addr) - int'(ADDR_CH_BASE);
      k      = int'(addr) - int'(ADDR_ALL_BASE);
      if (addr == ADDR_MODE1) begin
         mode_one = data & MODE1_MASK;
      end else if (addr == ADDR_MODE2) begin
         mode_two = data & MODE2_MASK;
      end else if (offset >= 0 && offset < 4*CHANNELS) begin
         led_bytes[offset] = data;
      end else if (k >= 0 && k < 4) begin
         for (int c = 0; c < CHANNELS; c++) begin
            led_bytes[4*c + k] = data;
         end
      end else if (addr == ADDR_PRESCALE && mode_one[BIT_SLEEP]) begin
         prescale = (data < PRESCALE_MIN) ? PRESCALE_MIN : data;
      end
   endfunction

   function automatic logic [7:0] fetch_byte(logic [7:0] addr);
      int offset;
      offset = int'(addr) - int'(ADDR_CH_BASE);
      if (addr == ADDR_MODE1) return mode_one;
      if (addr == ADDR_MODE2) return mode_two;
      if (offset >= 0 && offset < 4*CHANNELS) return led_bytes[offset];
      if (addr == ADDR_PRESCALE) return prescale;
      return 8'h00;
   endfunction

   function automatic pin_result_type predict_outputs(reg_request_type rq);
      pin_result_type r;
      r.read_data = '0;
      case (rq.operation)
         OP_WRITE: store_byte(rq.reg_addr, rq.write_data);
         OP_READ:  r.read_data = fetch_byte(rq.reg_addr);
         OP_TICK: begin
            // the counter stands still while asleep
            if (!mode_one[BIT_SLEEP]) begin
               if (divider >= prescale) begin
                  divider   = '0;
                  pwm_count = pwm_count + 1'b1;
               end else begin
                  divider = divider + 8'd1;
               end
            end
         end
         default: ;
      endcase
      r.pwm_pins = pin_levels();
      return r;
   endfunction

   always @(posedge clock) begin
      faults = 0;
      if (reset) begin
         load_reset_values();
         predicted_outputs.delete();
         error_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_outputs.push_back(predict_outputs(reg_request_type'(req_tdata[17:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = pin_result_type'(rsp_tdata);
            if (predicted_outputs.size() == 0) begin
               $display("%0t: result transaction with nothing predicted: %h %h",
                        $time, got.read_data, got.pwm_pins);
               faults++;
            end else begin
               want = predicted_outputs.pop_front();
               if (got.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, got.read_data);
                  faults++;
               end
               if (got.pwm_pins !== want.pwm_pins) begin
                  $display("%0t: pwm_pins expected %h actual %h",
                           $time, want.pwm_pins, got.pwm_pins);
                  faults++;
               end
            end
         end
         error_count <= error_count + faults;
      end
      pending_results <= predicted_outputs.size();
   end

endmodule

// ----- tb/tb_sixteen_channel_pwm_register_block.sv -----
// ---------------------------------------------------------------------------
// tb_sixteen_channel_pwm_register_block
// Drives byte writes, byte reads and oscillator ticks into the pwm register
// block with random stalls on both streams: a directed opening, a tick run
// across channel edges low in the count, then random register sequences
// and tick bursts.
// ---------------------------------------------------------------------------
module tb_sixteen_channel_pwm_register_block;
   import scpwm_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         RANDOM_ITEMS = 900;
   localparam int         EDGE_TICKS   = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // operation, reg_addr, write_data
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // read_data, pwm_pins

   int          error_count;
   int          pending_results;
   bit          no_idle    = 1'b0;
   int unsigned stall_left = 0;
   int          items_sent = 0;
   int          stop_at;
   int unsigned pick;

   always #1 clock = ~clock;

   sixteen_channel_pwm_register_block uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pwm_register_checker pin_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] addr,
                            input logic [7:0] data);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, data, addr, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   function automatic logic [7:0] chan_addr(int ch, logic [1:0] k);
      return 8'(int'(ADDR_CH_BASE) + 4*ch + int'(k));
   endfunction

   task automatic write_channel(input int ch, input logic [11:0] on_cnt,
                                input logic [11:0] off_cnt, input logic [7:0] on_flags,
                                input logic [7:0] off_flags, input bit broadcast);
      logic [7:0] bytes [4];
      bytes[BYTE_ON_L]  = on_cnt[7:0];
      bytes[BYTE_ON_H]  = {on_flags[7:4], on_cnt[11:8]};
      bytes[BYTE_OFF_L] = off_cnt[7:0];
      bytes[BYTE_OFF_H] = {off_flags[7:4], off_cnt[11:8]};
      for (int k = 0; k < 4; k++) begin
         send_item(OP_WRITE,
                   broadcast ? 8'(int'(ADDR_ALL_BASE) + k) : chan_addr(ch, 2'(k)),
                   bytes[k]);
      end
   endtask

   // prescale only sticks while asleep, so wrap the write in sleep and wake
   task automatic set_prescale(input logic [7:0] value, input logic [7:0] mode_bits);
      send_item(OP_WRITE, ADDR_MODE1, mode_bits | 8'(1 << BIT_SLEEP));
      send_item(OP_WRITE, ADDR_PRESCALE, value);
      send_item(OP_WRITE, ADDR_MODE1, mode_bits & ~8'(1 << BIT_SLEEP));
   endtask

   // the counter only gets a few hundred steps in per run, keep most edges low
   function automatic logic [11:0] random_count();
      if ($urandom_range(0, 4) != 0) return 12'($urandom_range(0, 400));
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [7:0] random_flags();
      logic [7:0] fl;
      fl = 8'($urandom) & 8'hE0;
      if ($urandom_range(0, 9) == 0) fl[BIT_FULL] = 1'b1;
      return fl;
   endfunction

   function automatic logic [7:0] mapped_addr();
      case ($urandom_range(0, 9))
         0: return ADDR_MODE1;
         1: return ADDR_MODE2;
         2: return ADDR_PRESCALE;
         3: return 8'(int'(ADDR_ALL_BASE) + $urandom_range(0, 3));
         4: return 8'($urandom);
         default: return chan_addr($urandom_range(0, 15), 2'($urandom));
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values, sleeping tick, mode masks, prescale clamp and lockout
      send_item(OP_READ, ADDR_MODE1, 8'h00);
      send_item(OP_READ, ADDR_MODE2, 8'h00);
      send_item(OP_READ, ADDR_PRESCALE, 8'h00);
      send_item(OP_READ, chan_addr(0, BYTE_OFF_H), 8'h00);
      send_item(OP_TICK, 8'hFF, 8'hFF);
      send_item(OP_WRITE, ADDR_MODE1, 8'hFF);
      send_item(OP_READ, ADDR_MODE1, 8'h00);
      send_item(OP_WRITE, ADDR_PRESCALE, 8'hFF);
      send_item(OP_READ, ADDR_PRESCALE, 8'h00);
      send_item(OP_WRITE, ADDR_PRESCALE, 8'h00);
      send_item(OP_WRITE, ADDR_PRESCALE, 8'h02);
      send_item(OP_WRITE, ADDR_MODE2, 8'hFF);
      send_item(OP_READ, ADDR_MODE2, 8'h00);
      send_item(OP_WRITE, ADDR_MODE1, 8'h00);
      send_item(OP_WRITE, ADDR_PRESCALE, 8'h40);
      send_item(OP_READ, ADDR_PRESCALE, 8'h00);
      // broadcast, full on against full off, unused space, unknown op
      send_item(OP_WRITE, 8'(int'(ADDR_ALL_BASE) + int'(BYTE_OFF_H)), 8'h00);
      send_item(OP_READ, 8'(int'(ADDR_ALL_BASE) + int'(BYTE_OFF_H)), 8'h00);
      send_item(OP_WRITE, chan_addr(14, BYTE_ON_H), 8'h1F);
      send_item(OP_WRITE, chan_addr(15, BYTE_ON_H), 8'h10);
      send_item(OP_WRITE, chan_addr(15, BYTE_OFF_H), 8'h10);
      send_item(OP_WRITE, 8'h03, 8'hAA);
      send_item(OP_READ, 8'h03, 8'h00);
      send_item(OP_WRITE, 8'h46, 8'h55);
      send_item(OP_READ, 8'h46, 8'h00);
      send_item(OP_WRITE, 8'hFF, 8'h12);
      send_item(OP_READ, 8'hFF, 8'h00);
      send_item(OP_UNUSED, ADDR_MODE1, 8'hFF);
      repeat (6) send_item(OP_TICK, 8'h00, 8'h00);
      wait_idle();

      // edges near both ends of the count, then a tick run across the low ones
      send_item(OP_WRITE, ADDR_MODE2, MODE2_RESET);
      set_prescale(PRESCALE_MIN, 8'h00);
      write_channel(0, 12'd4090, 12'd5, 8'h00, 8'h00, 1'b0);
      write_channel(1, 12'd4000, 12'd80, 8'h00, 8'h00, 1'b0);
      write_channel(2, 12'd0, 12'd4095, 8'h00, 8'h00, 1'b0);
      write_channel(3, 12'd4095, 12'd0, 8'h00, 8'h00, 1'b0);
      write_channel(4, 12'd50, 12'd51, 8'h00, 8'h00, 1'b0);
      no_idle <= 1'b1;
      repeat (EDGE_TICKS) send_item(OP_TICK, 8'($urandom), 8'($urandom));
      no_idle <= 1'b0;

      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         no_idle <= ($urandom_range(0, 9) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 24)) send_item(OP_TICK, 8'($urandom), 8'($urandom));
         end else if (pick < 50) begin
            write_channel($urandom_range(0, 15), random_count(), random_count(),
                          random_flags(), random_flags(), $urandom_range(0, 9) == 0);
         end else if (pick < 62) begin
            repeat ($urandom_range(1, 4)) send_item(OP_READ, mapped_addr(), 8'($urandom));
         end else if (pick < 70) begin
            set_prescale($urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom),
                         8'($urandom));
         end else if (pick < 76) begin
            send_item(OP_WRITE, ADDR_MODE2, 8'($urandom));
         end else if (pick < 82) begin
            send_item(OP_WRITE, ADDR_MODE1,
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) | 8'(1 << BIT_SLEEP)
                                                  : 8'($urandom) & ~8'(1 << BIT_SLEEP));
         end else if (pick < 88) begin
            send_item(OP_WRITE, ADDR_PRESCALE, 8'($urandom));
         end else begin
            send_item(2'($urandom), 8'($urandom), 8'($urandom));
         end
         if ($urandom_range(0, 39) == 0) wait_idle();
      end

      no_idle <= 1'b0;
      wait_idle();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("sixteen_channel_pwm_register_block test passed");
      end else begin
         $display("sixteen_channel_pwm_register_block test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("sixteen_channel_pwm_register_block test failed");
      $finish;
   end

endmodule
